// ===== rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and constants of the bitmap block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int BITMAP_BYTES_DEF = 128;
  localparam int WORD_BITS        = 64;
  localparam int BIT_IDX_W        = 6;
  localparam int INDEX_W          = 10;
  localparam int NUMBER_W         = 10;
  localparam int STATUS_W         = 2;
  localparam int COUNT_W          = 11;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_RANGE        = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_FREE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic scan_init;
    logic read;
    logic rd_index;
    logic set_full;
    logic set_range;
    logic set_already;
    logic alloc_commit;
    logic free_commit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic word_hit;
    logic bit_used;
    logic range_bad;
    logic count_zero;
    logic op_free;
  } stat_t;

endpackage

// ===== rtl/bba_if.sv =====
// ----------------------------------------------------------------------------
// bba request and response channels
// valid/ready channels carrying allocator requests and results
// ----------------------------------------------------------------------------
interface bba_req_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [bba_pkg::INDEX_W-1:0]  block_index;

  modport source (output valid, output opcode, output block_index, input ready);
  modport sink   (input valid, input opcode, input block_index, output ready);
endinterface

interface bba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bba_pkg::NUMBER_W-1:0]  block_number;
  logic [bba_pkg::STATUS_W-1:0]  status;
  logic [bba_pkg::COUNT_W-1:0]   free_count;

  modport source (output valid, output block_number, output status, output free_count,
                  input ready);
  modport sink   (input valid, input block_number, input status, input free_count,
                  output ready);
endinterface

// ===== rtl/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// request sequencer: clearing pass, decode, word scan, free check, result
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  bba_pkg::stat_t  stat,
  output bba_pkg::cmd_t   cmd
);

  bba_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      bba_pkg::S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = bba_pkg::S_DECIDE;
        end
      end
      bba_pkg::S_DECIDE: begin
        priority if (!stat.op_free && stat.count_zero) begin
          cmd.set_full = 1'b1;
          state_next   = bba_pkg::S_DONE;
        end else if (!stat.op_free) begin
          cmd.scan_init = 1'b1;
          state_next    = bba_pkg::S_SCAN;
        end else if (stat.range_bad) begin
          cmd.set_range = 1'b1;
          state_next    = bba_pkg::S_DONE;
        end else begin
          cmd.read     = 1'b1;
          cmd.rd_index = 1'b1;
          state_next   = bba_pkg::S_FREE;
        end
      end
      bba_pkg::S_SCAN: begin
        if (stat.word_hit) begin
          cmd.alloc_commit = 1'b1;
          state_next       = bba_pkg::S_DONE;
        end else begin
          cmd.read = 1'b1;
        end
      end
      bba_pkg::S_FREE: begin
        if (stat.bit_used) begin
          cmd.free_commit = 1'b1;
        end else begin
          cmd.set_already = 1'b1;
        end
        state_next = bba_pkg::S_DONE;
      end
      bba_pkg::S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = bba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bba_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bba_dpath.sv =====
// ----------------------------------------------------------------------------
// bba_dpath
// bitmap memory, scan pointer, lowest-free-bit search, free count, results
// ----------------------------------------------------------------------------
module bba_dpath #(
  parameter int BITMAP_BYTES = bba_pkg::BITMAP_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bba_pkg::cmd_t                 cmd,
  output bba_pkg::stat_t                stat,
  input  logic                          opcode,
  input  logic [bba_pkg::INDEX_W-1:0]   block_index,
  output logic [bba_pkg::NUMBER_W-1:0]  block_number,
  output logic [bba_pkg::STATUS_W-1:0]  status,
  output logic [bba_pkg::COUNT_W-1:0]   free_count
);

  localparam int WB         = bba_pkg::WORD_BITS;
  localparam int BI         = bba_pkg::BIT_IDX_W;
  localparam int NUM_BLOCKS = BITMAP_BYTES * 8;
  localparam int NUM_WORDS  = (BITMAP_BYTES + 7) / 8;
  localparam int WA         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int NW         = WA + BI;
  localparam int CW         = $clog2(NUM_BLOCKS + 1);
  localparam int LASTBITS   = NUM_BLOCKS - WB * (NUM_WORDS - 1);
  localparam int XW         = NW + bba_pkg::INDEX_W;
  localparam logic [WA-1:0] LAST_WORD = WA'(NUM_WORDS - 1);
  localparam logic [WB-1:0] PAD = ~((WB'(1) << LASTBITS) - WB'(1));
  localparam logic [XW-1:0] NB_X = XW'(NUM_BLOCKS);
  localparam logic [CW-1:0] NB_C = CW'(NUM_BLOCKS);

  logic [WB-1:0] mem [NUM_WORDS];

  logic                         op_q;
  logic [bba_pkg::INDEX_W-1:0]  index_q;
  logic [WA-1:0]                ptr;
  logic [WA-1:0]                rd_addr;
  logic [WA-1:0]                rd_addr_next;
  logic                         rd_valid;
  logic [WB-1:0]                rd_data;
  logic [CW-1:0]                count;
  logic [NW-1:0]                number;
  bba_pkg::status_t             status_q;

  logic [XW-1:0]  idx_ext;
  logic [WA-1:0]  idx_word;
  logic [BI-1:0]  idx_bit;
  logic [WB-1:0]  masked;
  logic [BI-1:0]  free_bit;
  logic           wr_en;
  logic [WA-1:0]  wr_addr;
  logic [WB-1:0]  wr_data;
  logic [XW-1:0]  number_ext;
  logic [CW+bba_pkg::COUNT_W-1:0] count_ext;

  assign idx_ext  = {{NW{1'b0}}, index_q};
  assign idx_word = idx_ext[NW-1:BI];
  assign idx_bit  = index_q[BI-1:0];
  assign masked   = rd_data | ((rd_addr == LAST_WORD) ? PAD : '0);

  always_comb begin
    free_bit = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (!masked[i]) begin
        free_bit = BI'(i);
      end
    end
  end

  assign rd_addr_next = cmd.rd_index ? idx_word : ptr;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr;
    wr_data = '0;
    priority if (cmd.clear) begin
      wr_en   = 1'b1;
      wr_addr = ptr;
    end else if (cmd.alloc_commit) begin
      wr_en   = 1'b1;
      wr_data = rd_data | (WB'(1) << free_bit);
    end else if (cmd.free_commit) begin
      wr_en   = 1'b1;
      wr_data = rd_data & ~(WB'(1) << idx_bit);
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.read) begin
      rd_data <= mem[rd_addr_next];
      rd_addr <= rd_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      rd_valid <= 1'b0;
      count    <= NB_C;
    end else begin
      rd_valid <= cmd.read;
      if (cmd.scan_init) begin
        ptr <= '0;
      end else if ((cmd.clear || (cmd.read && !cmd.rd_index)) && ptr != LAST_WORD) begin
        ptr <= ptr + WA'(1);
      end
      if (cmd.alloc_commit) begin
        count <= count - CW'(1);
      end else if (cmd.free_commit) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= opcode;
      index_q <= block_index;
    end
    priority if (cmd.set_full) begin
      status_q <= bba_pkg::ST_FULL;
      number   <= '0;
    end else if (cmd.set_range) begin
      status_q <= bba_pkg::ST_RANGE;
      number   <= '0;
    end else if (cmd.set_already) begin
      status_q <= bba_pkg::ST_ALREADY_FREE;
      number   <= '0;
    end else if (cmd.free_commit) begin
      status_q <= bba_pkg::ST_OK;
      number   <= '0;
    end else if (cmd.alloc_commit) begin
      status_q <= bba_pkg::ST_OK;
      number   <= {rd_addr, free_bit};
    end else begin
      status_q <= status_q;
    end
  end

  assign stat.clear_last = (ptr == LAST_WORD);
  assign stat.word_hit   = rd_valid && (masked != '1);
  assign stat.bit_used   = rd_data[idx_bit];
  assign stat.range_bad  = (idx_ext >= NB_X);
  assign stat.count_zero = (count == '0);
  assign stat.op_free    = (op_q == bba_pkg::OP_FREE);

  assign number_ext   = {{bba_pkg::INDEX_W{1'b0}}, number};
  assign count_ext    = {{bba_pkg::COUNT_W{1'b0}}, count};
  assign block_number = number_ext[bba_pkg::NUMBER_W-1:0];
  assign status       = status_q;
  assign free_count   = count_ext[bba_pkg::COUNT_W-1:0];

endmodule

// ===== rtl/block_bitmap_allocator_top.sv =====
// ----------------------------------------------------------------------------
// block_bitmap_allocator_top
// first-fit bitmap block allocator with free-block count
// ----------------------------------------------------------------------------
// One request is handled at a time. After reset a clearing pass writes the
// bitmap one 64-bit word a cycle (BITMAP_BYTES/8 rounded up words, 16 at the
// default size) before the first request is taken. A free reads the word that
// holds its block and then clears its bit if it is in use, with no read when
// its index is out of range. An allocate with free blocks left scans the bitmap
// memory one word per cycle through its single read port, from word 0 up to
// the first word with a free block; an allocate with no free block does no
// scan. The result is held until its transfer out, and the next request is
// taken the cycle after.
module block_bitmap_allocator_top #(
  parameter int BITMAP_BYTES = bba_pkg::BITMAP_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bba_req_if.sink   req,
  bba_rsp_if.source rsp
);

  bba_pkg::cmd_t  cmd;
  bba_pkg::stat_t stat;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bba_dpath #(
    .BITMAP_BYTES (BITMAP_BYTES)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .opcode       (req.opcode),
    .block_index  (req.block_index),
    .block_number (rsp.block_number),
    .status       (rsp.status),
    .free_count   (rsp.free_count)
  );

endmodule

// ===== sim/tb_block_bitmap_allocator_top.sv =====
// ----------------------------------------------------------------------------
// tb_block_bitmap_allocator_top
// Self-checking bench for the first-fit block allocator. Requests go in through
// a queue-fed driver and results are checked one by one against a bitmap
// predictor in the bench. The run has a short directed opening, then a long
// phase that is mostly allocates and fills the map until it is full, then a
// phase that is mostly frees. Both sides take random gaps. There is one long
// response hold-off and one drain pause.
// ----------------------------------------------------------------------------
module tb_block_bitmap_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int INDEX_W   = bba_pkg::INDEX_W;
  localparam int NUMBER_W  = bba_pkg::NUMBER_W;
  localparam int COUNT_W   = bba_pkg::COUNT_W;
  localparam int WORD_BITS = bba_pkg::WORD_BITS;
  localparam int NBYTES    = bba_pkg::BITMAP_BYTES_DEF;
  localparam int NBLOCKS   = NBYTES * 8;
  localparam int NWORDS    = (NBYTES + 7) / 8;
  localparam int LONG_HOLD = 300;

  typedef struct {
    bba_pkg::opcode_t       op;
    logic [INDEX_W-1:0]     idx;
  } alloc_req_t;

  typedef struct {
    logic [NUMBER_W-1:0]    block_number;
    bba_pkg::status_t       status;
    logic [COUNT_W-1:0]     free_count;
  } alloc_result_t;

  logic clk;
  logic rst;

  bba_req_if req_ch ();
  bba_rsp_if rsp_ch ();

  block_bitmap_allocator_top #(
    .BITMAP_BYTES(NBYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  alloc_req_t             pending_reqs[$];
  alloc_result_t          due_results[$];
  logic [WORD_BITS-1:0]   taken_map[NWORDS] = '{default: '0};
  logic [COUNT_W-1:0]     free_left = NBLOCKS[COUNT_W-1:0];
  int                     full_replies = 0;
  int                     mismatches = 0;
  bit                     gaps_on;
  bit                     long_stall_go;
  bit                     long_stall_done;
  int                     hold_left;
  int                     src_gap;
  int                     sink_gap;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic alloc_result_t allocator_outcome(bba_pkg::opcode_t op,
                                                      logic [INDEX_W-1:0] idx);
    alloc_result_t r;
    bit            found;
    int            n;
    r.block_number = '0;
    r.status       = bba_pkg::ST_OK;
    found          = 1'b0;
    if (op == bba_pkg::OP_ALLOC) begin
      for (n = 0; n < NBLOCKS && !found; n++) begin
        if (!taken_map[n / WORD_BITS][n % WORD_BITS]) begin
          taken_map[n / WORD_BITS][n % WORD_BITS] = 1'b1;
          free_left      = free_left - 1'b1;
          r.block_number = NUMBER_W'(n);
          found          = 1'b1;
        end
      end
      if (!found) begin
        r.status = bba_pkg::ST_FULL;
        full_replies++;
      end
    end else if (int'(idx) >= NBLOCKS) begin
      r.status = bba_pkg::ST_RANGE;
    end else if (!taken_map[idx / WORD_BITS][idx % WORD_BITS]) begin
      r.status = bba_pkg::ST_ALREADY_FREE;
    end else begin
      taken_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
      free_left = free_left + 1'b1;
    end
    r.free_count = free_left;
    return r;
  endfunction

  // mostly a block that is in use now, sometimes any index at all
  function automatic logic [INDEX_W-1:0] pick_free_target();
    int start;
    int k;
    int n;
    case ($urandom_range(0, 9))
      0, 1: return INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
      2: return INDEX_W'($urandom_range(0, NBLOCKS - 1));
      default: begin
        start = $urandom_range(0, NBLOCKS - 1);
        for (k = 0; k < NBLOCKS; k++) begin
          n = (start + k) % NBLOCKS;
          if (taken_map[n / WORD_BITS][n % WORD_BITS]) return INDEX_W'(n);
        end
        return INDEX_W'(start);
      end
    endcase
  endfunction

  task automatic queue_request(bba_pkg::opcode_t op, logic [INDEX_W-1:0] idx);
    alloc_req_t item;
    item.op  = op;
    item.idx = idx;
    while (pending_reqs.size() >= 2) @(negedge clk);
    pending_reqs.push_back(item);
  endtask

  task automatic queue_random(int alloc_pct);
    if ($urandom_range(0, 99) < alloc_pct) begin
      queue_request(bba_pkg::OP_ALLOC, INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1)));
    end else begin
      queue_request(bba_pkg::OP_FREE, pick_free_target());
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_ch.valid || due_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // request driver, predicts each transfer as it is accepted
  always @(posedge clk) begin
    alloc_req_t item;
    if (rst) begin
      req_ch.valid <= 1'b0;
      src_gap      <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        due_results.push_back(allocator_outcome(bba_pkg::opcode_t'(req_ch.opcode),
                                                req_ch.block_index));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (src_gap > 0) begin
          req_ch.valid <= 1'b0;
          src_gap      <= src_gap - 1;
        end else if (pending_reqs.size() != 0) begin
          if (gaps_on && $urandom_range(0, 9) == 0) begin
            req_ch.valid <= 1'b0;
            src_gap      <= $urandom_range(0, 15);
          end else begin
            item = pending_reqs.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.opcode      <= item.op;
            req_ch.block_index <= item.idx;
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response ready, with random gaps and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready    <= 1'b0;
      hold_left       <= 0;
      sink_gap        <= 0;
      long_stall_done <= 1'b0;
    end else if (long_stall_go && !long_stall_done) begin
      rsp_ch.ready    <= 1'b0;
      hold_left       <= LONG_HOLD - 1;
      long_stall_done <= 1'b1;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (sink_gap > 0) begin
      rsp_ch.ready <= 1'b0;
      sink_gap     <= sink_gap - 1;
    end else if (gaps_on && $urandom_range(0, 9) == 0) begin
      rsp_ch.ready <= 1'b0;
      sink_gap     <= $urandom_range(0, 15);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual block %0d status %0d count %0d",
                 $realtime, rsp_ch.block_number, rsp_ch.status, rsp_ch.free_count);
        mismatches++;
      end else begin
        exp_r = due_results.pop_front();
        if (rsp_ch.block_number !== exp_r.block_number) begin
          $display("%0t: block_number expected %0d actual %0d",
                   $realtime, exp_r.block_number, rsp_ch.block_number);
          mismatches++;
        end
        if (rsp_ch.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $realtime, exp_r.status, rsp_ch.status);
          mismatches++;
        end
        if (rsp_ch.free_count !== exp_r.free_count) begin
          $display("%0t: free_count expected %0d actual %0d",
                   $realtime, exp_r.free_count, rsp_ch.free_count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int i;
    int fill_items;
    rst           = 1'b1;
    gaps_on       = 1'b1;
    long_stall_go = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed opening
    queue_request(bba_pkg::OP_ALLOC, '0);
    queue_request(bba_pkg::OP_ALLOC, '0);
    queue_request(bba_pkg::OP_ALLOC, '0);
    queue_request(bba_pkg::OP_FREE, INDEX_W'(1));
    queue_request(bba_pkg::OP_FREE, INDEX_W'(1));
    queue_request(bba_pkg::OP_ALLOC, '1);
    queue_request(bba_pkg::OP_FREE, '1);
    queue_request(bba_pkg::OP_FREE, INDEX_W'(NBLOCKS));
    queue_request(bba_pkg::OP_FREE, INDEX_W'(NBLOCKS - 1));
    queue_request(bba_pkg::OP_ALLOC, INDEX_W'(10'h2AA));
    queue_request(bba_pkg::OP_ALLOC, INDEX_W'(10'h155));
    queue_request(bba_pkg::OP_FREE, INDEX_W'(10'h155));
    queue_request(bba_pkg::OP_FREE, INDEX_W'(10'h2AA));
    queue_request(bba_pkg::OP_FREE, '0);
    queue_request(bba_pkg::OP_FREE, '0);
    queue_request(bba_pkg::OP_FREE, INDEX_W'(3));
    queue_request(bba_pkg::OP_ALLOC, '0);
    queue_request(bba_pkg::OP_FREE, INDEX_W'(2));

    // sender pause until everything is back
    wait_drained();

    // fill phase, runs on past the first full replies
    fill_items = 0;
    while (full_replies < 10 && fill_items < 1120) begin
      if (fill_items == 300) long_stall_go = 1'b1;
      queue_random(98);
      fill_items++;
    end

    // drain phase, the last stretch without gaps
    for (i = 0; i < 60; i++) begin
      if (i == 20) gaps_on = 1'b0;
      queue_random(20);
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bba_pkg.sv
rtl/bba_if.sv
rtl/bba_ctrl.sv
rtl/bba_dpath.sv
rtl/block_bitmap_allocator_top.sv
sim/tb_block_bitmap_allocator_top.sv
